@@ rtl/core/bnlms_pkg.sv @@
// Package for the block NLMS adaptive filter: widths, defaults, controller state type.
// No dependencies.
package bnlms_pkg;
  localparam int unsigned TapsDefault  = 16;
  localparam int unsigned BlockDefault = 8;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned WeightW      = 32;
  localparam int unsigned StepW        = 16;
  localparam int unsigned IndexW       = 4;
  localparam logic [StepW-1:0] StepReset = 16'd66;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROW_CLR, ST_ROW_MAC, ST_ROW_ERR, ST_DIV, ST_DIV_END,
    ST_TAP_CLR, ST_TAP_MAC, ST_TAP_SCALE, ST_TAP_WB, ST_EMIT, ST_SHIFT
  } ctrl_state_e;

  typedef struct packed {
    logic store;
    logic acc_clr;
    logic row_mac;
    logic row_err;
    logic div_start;
    logic div_end;
    logic tap_mac;
    logic tap_scale;
    logic tap_wb;
    logic shift;
  } dp_cmd_t;
endpackage

@@ rtl/core/bnlms_div.sv @@
// Restoring divider, one quotient bit per cycle, signed result truncated toward zero.
// No dependencies.
module bnlms_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            neg_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quot_o,
  output logic            neg_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d, trial;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, neg_q;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= neg_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign neg_o  = neg_q;
endmodule

@@ rtl/core/bnlms_dp.sv @@
// Datapath: sample stores, weights, multiply-accumulate paths, row scale store, divider.
// Depends on bnlms_pkg and bnlms_div.
module bnlms_dp
  import bnlms_pkg::*;
#(
  parameter int unsigned TAPS  = TapsDefault,
  parameter int unsigned BLOCK = BlockDefault,
  localparam int unsigned HistLen = BLOCK + TAPS - 1,
  localparam int unsigned HistW   = $clog2(HistLen),
  localparam int unsigned TapW    = (TAPS > 1) ? $clog2(TAPS) : 1,
  localparam int unsigned RowW    = (BLOCK > 1) ? $clog2(BLOCK) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [RowW-1:0]     slot_i,
  input  logic [RowW-1:0]     row_i,
  input  logic [TapW-1:0]     tap_i,
  input  logic [SampleW-1:0]  ref_i,
  input  logic [SampleW-1:0]  des_i,
  input  logic [StepW-1:0]    step_i,
  output logic                div_busy_o,
  output logic [WeightW-1:0]  weight_o
);
  localparam int unsigned AccW = 56;
  localparam logic signed [63:0] SMax = 64'sd2147483647;
  localparam logic signed [63:0] SMin = -64'sd2147483648;

  logic signed [SampleW-1:0] hist_q [HistLen];
  logic signed [SampleW-1:0] des_q  [BLOCK];
  logic signed [WeightW-1:0] w_q    [TAPS];
  logic signed [WeightW-1:0] scale_q [BLOCK];
  logic signed [AccW-1:0]    dot_q;
  logic [40:0]               nrg_q;
  logic signed [63:0]        e29_q;
  logic signed [63:0]        acc_q;
  logic signed [63:0]        s29_q;
  logic signed [SampleW-1:0] h_sel;
  logic signed [WeightW-1:0] w_sel;
  logic signed [WeightW-1:0] sc_sel;
  logic signed [63:0]        prod_w, prod_h, prod_s;
  logic signed [63:0]        err44, e29_d, num_s, delta, wsum;
  logic [63:0]               num_mag, quot;
  logic                      quot_neg;
  logic [HistW-1:0]          hidx;

  // row plus tap never exceeds HistLen-1
  assign hidx   = HistW'(row_i) + HistW'(tap_i);
  assign h_sel  = hist_q[hidx];
  assign w_sel  = w_q[tap_i];
  assign sc_sel = scale_q[row_i];
  assign prod_w = 64'(h_sel) * 64'(w_sel);
  assign prod_h = 64'(h_sel) * 64'(h_sel);
  assign prod_s = 64'(h_sel) * 64'(sc_sel);

  assign err44 = (64'(des_q[row_i]) <<< 29) - 64'(dot_q);
  assign e29_d = err44 >>> 15;
  assign num_s = e29_q <<< 25;
  assign num_mag = num_s[63] ? 64'(-num_s) : 64'(num_s);

  bnlms_div #(.NumW(64), .DenW(41)) u_div (
    .clk_i, .rst_ni,
    .start_i (cmd_i.div_start),
    .neg_i   (num_s[63]),
    .num_i   (num_mag),
    .den_i   (nrg_q),
    .busy_o  (div_busy_o),
    .quot_o  (quot),
    .neg_o   (quot_neg)
  );

  assign delta = (s29_q * $signed({48'd0, step_i})) >>> 16;
  assign wsum  = 64'(w_sel) + delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistLen; i++) hist_q[i] <= '0;
      for (int i = 0; i < BLOCK; i++) des_q[i] <= '0;
      for (int i = 0; i < TAPS; i++) w_q[i] <= '0;
    end else begin
      if (cmd_i.store) begin
        hist_q[HistW'(slot_i)] <= ref_i;
        des_q[slot_i]  <= des_i;
      end
      if (cmd_i.tap_wb) begin
        if (wsum > SMax) w_q[tap_i] <= SMax[31:0];
        else if (wsum < SMin) w_q[tap_i] <= SMin[31:0];
        else w_q[tap_i] <= wsum[31:0];
      end
      if (cmd_i.shift) begin
        for (int i = BLOCK; i < HistLen; i++) hist_q[i] <= hist_q[i-BLOCK];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      dot_q <= '0;
      nrg_q <= '0;
      acc_q <= '0;
    end
    if (cmd_i.row_mac) begin
      dot_q <= dot_q + AccW'(prod_w);
      nrg_q <= nrg_q + 41'(prod_h);
    end
    if (cmd_i.row_err) e29_q <= e29_d;
    if (cmd_i.div_end) begin
      // zero energy row contributes nothing; quotient saturates to 32 bits
      if (nrg_q == '0) scale_q[row_i] <= '0;
      else if (!quot_neg && quot > 64'(SMax)) scale_q[row_i] <= SMax[31:0];
      else if (quot_neg && quot > 64'h80000000) scale_q[row_i] <= SMin[31:0];
      else scale_q[row_i] <= quot_neg ? 32'(-quot) : quot[31:0];
    end
    if (cmd_i.tap_mac) acc_q <= acc_q + prod_s;
    if (cmd_i.tap_scale) s29_q <= acc_q >>> 10;
  end

  assign weight_o = w_sel;
endmodule

@@ rtl/core/bnlms_ctrl.sv @@
// Controller: sequences store, row pass, division, tap pass, report and shift.
// Depends on bnlms_pkg.
module bnlms_ctrl
  import bnlms_pkg::*;
#(
  parameter int unsigned TAPS  = TapsDefault,
  parameter int unsigned BLOCK = BlockDefault,
  localparam int unsigned TapW = (TAPS > 1) ? $clog2(TAPS) : 1,
  localparam int unsigned RowW = (BLOCK > 1) ? $clog2(BLOCK) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_ready_i,
  input  logic            div_busy_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output logic            last_o,
  output dp_cmd_t         cmd_o,
  output logic [RowW-1:0] slot_o,
  output logic [RowW-1:0] row_o,
  output logic [TapW-1:0] tap_o
);
  ctrl_state_e state_q, state_d;
  logic [RowW-1:0] cnt_q, cnt_d, row_q, row_d;
  logic [TapW-1:0] tap_q, tap_d;
  logic row_end, tap_end, last_samp;

  assign row_end   = row_q == RowW'(BLOCK - 1);
  assign tap_end   = tap_q == TapW'(TAPS - 1);
  assign last_samp = cnt_q == RowW'(BLOCK - 1);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    row_d = row_q;
    tap_d = tap_q;
    case (state_q)
      ST_IDLE: if (in_fire_i) begin
        cnt_d = last_samp ? '0 : cnt_q + 1'b1;
        if (last_samp) begin
          state_d = ST_ROW_CLR;
          row_d = '0;
        end
      end
      ST_ROW_CLR: begin
        state_d = ST_ROW_MAC;
        tap_d = '0;
      end
      ST_ROW_MAC: begin
        tap_d = tap_end ? '0 : tap_q + 1'b1;
        if (tap_end) state_d = ST_ROW_ERR;
      end
      ST_ROW_ERR: state_d = ST_DIV;
      ST_DIV: state_d = ST_DIV_END;
      ST_DIV_END: if (!div_busy_i) begin
        if (row_end) begin
          state_d = ST_TAP_CLR;
          tap_d = '0;
        end else begin
          state_d = ST_ROW_CLR;
        end
        row_d = row_q + 1'b1;
        if (row_end) row_d = '0;
      end
      ST_TAP_CLR: begin
        state_d = ST_TAP_MAC;
        row_d = '0;
      end
      ST_TAP_MAC: begin
        row_d = row_end ? '0 : row_q + 1'b1;
        if (row_end) state_d = ST_TAP_SCALE;
      end
      ST_TAP_SCALE: state_d = ST_TAP_WB;
      ST_TAP_WB: begin
        if (tap_end) begin
          state_d = ST_EMIT;
          tap_d = '0;
        end else begin
          state_d = ST_TAP_CLR;
          tap_d = tap_q + 1'b1;
        end
      end
      ST_EMIT: if (out_ready_i) begin
        if (tap_end) state_d = ST_SHIFT;
        else tap_d = tap_q + 1'b1;
      end
      ST_SHIFT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.store = in_fire_i;
      end
      ST_ROW_CLR:   cmd_o.acc_clr = 1'b1;
      ST_ROW_MAC:   cmd_o.row_mac = 1'b1;
      ST_ROW_ERR:   cmd_o.row_err = 1'b1;
      ST_DIV:       cmd_o.div_start = 1'b1;
      ST_DIV_END:   cmd_o.div_end = !div_busy_i;
      ST_TAP_CLR:   cmd_o.acc_clr = 1'b1;
      ST_TAP_MAC:   cmd_o.tap_mac = 1'b1;
      ST_TAP_SCALE: cmd_o.tap_scale = 1'b1;
      ST_TAP_WB:    cmd_o.tap_wb = 1'b1;
      ST_EMIT:      out_valid_o = 1'b1;
      ST_SHIFT:     cmd_o.shift = 1'b1;
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      row_q <= '0;
      tap_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      row_q <= row_d;
      tap_q <= tap_d;
    end
  end

  assign slot_o = RowW'(BLOCK - 1) - cnt_q;
  assign row_o  = row_q;
  assign tap_o  = tap_q;
  assign last_o = tap_end;
endmodule

@@ rtl/core/block_nlms_adaptive_filter_top.sv @@
// Block NLMS adaptive filter, top level: controller plus datapath and stream ports.
// Depends on bnlms_pkg, bnlms_ctrl, bnlms_dp.
//
// Samples are taken one a cycle while the block collects; on the sample that
// completes a block of BLOCK, the multiply-accumulate datapath makes a pass per
// row for its error and energy, a bit-serial divider then runs once for that row,
// a second pass, tap by tap, updates the weights, then TAPS transactions report
// the weights with tlast on the final tap, and a shift state moves the history.
// No input is accepted during that update and report.
module block_nlms_adaptive_filter_top
  import bnlms_pkg::*;
#(
  parameter int unsigned TAPS  = TapsDefault,
  parameter int unsigned BLOCK = BlockDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // step_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [15:0] ref_sample, [31:16] desired_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // tap_weight
  output logic [3:0]  m_axis_tuser,    // tap_index
  output logic        m_axis_tlast
);
  localparam int unsigned TapW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned RowW = (BLOCK > 1) ? $clog2(BLOCK) : 1;

  logic [StepW-1:0] step_q;
  dp_cmd_t cmd;
  logic [RowW-1:0] slot, row;
  logic [TapW-1:0] tap;
  logic div_busy, in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= StepReset;
    else if (cfg_we_i) step_q <= cfg_wdata_i;
  end

  bnlms_ctrl #(.TAPS(TAPS), .BLOCK(BLOCK)) u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i   (in_fire),
    .out_ready_i (m_axis_tready),
    .div_busy_i  (div_busy),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .last_o      (m_axis_tlast),
    .cmd_o       (cmd),
    .slot_o      (slot),
    .row_o       (row),
    .tap_o       (tap)
  );

  bnlms_dp #(.TAPS(TAPS), .BLOCK(BLOCK)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .slot_i     (slot),
    .row_i      (row),
    .tap_i      (tap),
    .ref_i      (s_axis_tdata[15:0]),
    .des_i      (s_axis_tdata[31:16]),
    .step_i     (step_q),
    .div_busy_o (div_busy),
    .weight_o   (m_axis_tdata)
  );

  assign m_axis_tuser = 4'(tap);

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken during report");
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tready |=> !m_axis_tvalid)
    else $error("report ran past last tap");
  a_div_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !div_busy) else $error("divider busy during report");
endmodule
